/* rtl/erbt_pkg.sv */
`timescale 1ns / 1ps

package erbt_pkg;

   // Default coordinate width and coefficient fraction width.
   localparam int COORD_WIDTH_DEF = 24;
   localparam int COEF_FRAC_DEF   = 16;

   // Angle registers are radians times 4096, always 16 bits.
   localparam int ANGLE_WIDTH = 16;

   // Register map of the write port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_PSI   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_THETA = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_PHI   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_X    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_Y    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_Z    = 3'd5;

   // Series arithmetic is unsigned with 60 fraction bits; values stay at or below 1.0.
   localparam int Q60_WIDTH = 61;
   localparam int Q60_FRAC  = 60;
   localparam logic [63:0] HALF_PI_Q60    = 64'h1921FB54442D1847;
   localparam logic [63:0] QUARTER_PI_Q60 = HALF_PI_Q60 >> 1;

   // Series terms stop at this order.
   localparam logic [5:0] TERM_LIMIT = 6'd40;

   // Divisors (n+1)(n+2) of the series stay below 2^11.
   localparam int DIV_WIDTH = 11;

endpackage

/* rtl/erbt_req_if.sv */
`timescale 1ns / 1ps

interface erbt_req_if #(
   parameter int COORD_WIDTH = erbt_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] coord_x;
   logic signed [COORD_WIDTH-1:0] coord_y;
   logic signed [COORD_WIDTH-1:0] coord_z;
   logic                          last_atom;

   modport source (output valid, coord_x, coord_y, coord_z, last_atom, input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, last_atom, output ready);
endinterface

/* rtl/erbt_rsp_if.sv */
`timescale 1ns / 1ps

interface erbt_rsp_if #(
   parameter int COORD_WIDTH = erbt_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;
   logic                          last_out;
   logic                          clipped;

   modport source (output valid, out_x, out_y, out_z, last_out, clipped, input ready);
   modport sink (input valid, out_x, out_y, out_z, last_out, clipped, output ready);
endinterface

/* rtl/erbt_coef.sv */
`timescale 1ns / 1ps

module erbt_coef #(
   parameter int COEF_FRAC = erbt_pkg::COEF_FRAC_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [erbt_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [erbt_pkg::ANGLE_WIDTH-1:0]         csr_angle,
   output logic                                     busy,
   output logic signed [COEF_FRAC+2:0]              coef [9]
);
   import erbt_pkg::*;

   localparam int CW = COEF_FRAC + 3;
   localparam int PW = 2 * CW;
   localparam int QW = Q60_WIDTH;
   localparam int AW = 2 * QW;
   localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< COEF_FRAC;
   localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (COEF_FRAC - 1);
   localparam logic [QW-1:0] ONE_Q = QW'(1) << Q60_FRAC;
   localparam logic [QW-1:0] HALF_Q = QW'(1) << (Q60_FRAC - 1 - COEF_FRAC);
   localparam logic [3:0] DEST_U = 4'd9;
   localparam logic [3:0] DEST_W = 4'd10;
   localparam logic [3:0] LAST_STEP = 4'd14;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_REDUCE, ST_FOLD, ST_CHECK, ST_MUL, ST_DIV, ST_ACC,
      ST_FIN, ST_MAT_MUL, ST_MAT_ACC
   } state_type;

   typedef enum logic [3:0] {
      OPS_SPS, OPS_CPS, OPS_STH, OPS_CTH, OPS_SPH, OPS_CPH, OPS_U, OPS_W, OPS_ONE
   } opsel_type;

   typedef enum logic [1:0] {MODE_SET, MODE_NEG, MODE_ADD, MODE_SUB} mode_type;

   typedef struct packed {
      opsel_type  op_a;
      opsel_type  op_b;
      logic [3:0] dest;
      mode_type   mode;
   } mstep_type;

   // One product per step; rows of the matrix are built up from rounded products.
   function automatic mstep_type step_decode(input logic [3:0] s);
      mstep_type d;
      d = '{OPS_CTH, OPS_ONE, 4'd8, MODE_SET};
      case (s)
         4'd0:  d = '{OPS_CTH, OPS_SPH, DEST_U, MODE_SET};
         4'd1:  d = '{OPS_CTH, OPS_CPH, DEST_W, MODE_SET};
         4'd2:  d = '{OPS_CPS, OPS_CPH, 4'd0, MODE_SET};
         4'd3:  d = '{OPS_SPS, OPS_U, 4'd0, MODE_SUB};
         4'd4:  d = '{OPS_CPS, OPS_SPH, 4'd1, MODE_NEG};
         4'd5:  d = '{OPS_SPS, OPS_W, 4'd1, MODE_SUB};
         4'd6:  d = '{OPS_SPS, OPS_STH, 4'd2, MODE_SET};
         4'd7:  d = '{OPS_SPS, OPS_CPH, 4'd3, MODE_SET};
         4'd8:  d = '{OPS_CPS, OPS_U, 4'd3, MODE_ADD};
         4'd9:  d = '{OPS_SPS, OPS_SPH, 4'd4, MODE_NEG};
         4'd10: d = '{OPS_CPS, OPS_W, 4'd4, MODE_ADD};
         4'd11: d = '{OPS_CPS, OPS_STH, 4'd5, MODE_NEG};
         4'd12: d = '{OPS_STH, OPS_SPH, 4'd6, MODE_SET};
         4'd13: d = '{OPS_STH, OPS_CPH, 4'd7, MODE_SET};
         default: d = '{OPS_CTH, OPS_ONE, 4'd8, MODE_SET};
      endcase
      return d;
   endfunction

   state_type                 state_ff;
   logic [1:0]                idx_ff;
   logic [ANGLE_WIDTH-1:0]    psi_ff, theta_ff, phi_ff;
   logic                      neg_ff;
   logic [2:0]                k_ff;
   logic [63:0]               x_ff;
   logic                      swap_ff;
   logic                      cos_phase_ff;
   logic [5:0]                n_ff;
   logic [QW-1:0]             term_ff, ssum_ff, csum_ff, t_ff, q_ff;
   logic                      mpass_ff;
   logic [1:0]                mstep_ff;
   logic [AW-1:0]             acc_ff;
   logic [DIV_WIDTH-1:0]      rem_ff;
   logic [5:0]                dcnt_ff;
   logic signed [CW-1:0]      sps_ff, cps_ff, sth_ff, cth_ff, sph_ff, cph_ff, u_ff, w_ff;
   logic [3:0]                step_ff;
   logic signed [PW-1:0]      prod_ff;
   logic signed [CW-1:0]      mat_ff [9];

   logic                      angle_wr;
   logic [ANGLE_WIDTH-1:0]    angle_sel, mag;
   logic [QW-1:0]             ma, mb;
   logic [31:0]               a_half, b_half;
   logic [63:0]               pp;
   logic [AW-1:0]             pp_sh, acc_sum;
   logic [6:0]                n1, n2;
   logic [13:0]               dprod;
   logic [DIV_WIDTH-1:0]      dvsr;
   logic [DIV_WIDTH:0]        r2;
   logic                      qbit;
   logic [QW-1:0]             sfin, cfin, rnd_s, rnd_c, sum_upd;
   logic signed [CW-1:0]      rs, rc, s_q, c_q, s_f;
   mstep_type                 cur_step;
   logic signed [CW-1:0]      op_a_val, op_b_val, pval, cur_val, new_val;
   logic signed [PW-1:0]      rnd_p;

   assign angle_wr = csr_wr_en &&
                     (csr_index inside {CSR_ANGLE_PSI, CSR_ANGLE_THETA, CSR_ANGLE_PHI});
   assign busy = (state_ff != ST_IDLE);
   assign coef = mat_ff;

   // Angle selection and magnitude
   always_comb begin
      case (idx_ff)
         2'd0:    angle_sel = psi_ff;
         2'd1:    angle_sel = theta_ff;
         default: angle_sel = phi_ff;
      endcase
      mag = angle_sel[ANGLE_WIDTH-1] ? (~angle_sel + 1'b1) : angle_sel;
   end

   // 61 x 61 bit product in four 32 x 32 bit steps
   always_comb begin
      ma = mpass_ff ? t_ff : term_ff;
      mb = x_ff[QW-1:0];
      case (mstep_ff)
         2'd0: begin
            a_half = ma[31:0];
            b_half = mb[31:0];
         end
         2'd1: begin
            a_half = ma[31:0];
            b_half = 32'(mb[QW-1:32]);
         end
         2'd2: begin
            a_half = 32'(ma[QW-1:32]);
            b_half = mb[31:0];
         end
         default: begin
            a_half = 32'(ma[QW-1:32]);
            b_half = 32'(mb[QW-1:32]);
         end
      endcase
      pp = a_half * b_half;
      case (mstep_ff)
         2'd0:    pp_sh = AW'(pp);
         2'd1:    pp_sh = AW'(pp) << 32;
         2'd2:    pp_sh = AW'(pp) << 32;
         default: pp_sh = AW'(pp) << 64;
      endcase
      acc_sum = ((mstep_ff == 2'd0) ? '0 : acc_ff) + pp_sh;
   end

   // Restoring division by (n+1)(n+2), one quotient bit a cycle
   always_comb begin
      n1    = 7'(n_ff) + 7'd1;
      n2    = 7'(n_ff) + 7'd2;
      dprod = n1 * n2;
      dvsr  = dprod[DIV_WIDTH-1:0];
      r2    = {rem_ff, t_ff[QW-1]};
      qbit  = (r2 >= {1'b0, dvsr});
   end

   // Series update: sign alternates with bit 1 of the order
   always_comb begin
      if (cos_phase_ff) begin
         sum_upd = n_ff[1] ? csum_ff + q_ff : csum_ff - q_ff;
      end else begin
         sum_upd = n_ff[1] ? ssum_ff + q_ff : ssum_ff - q_ff;
      end
   end

   // Octant swap, rounding to the coefficient grid, quadrant fix-up and sign
   always_comb begin
      sfin  = swap_ff ? csum_ff : ssum_ff;
      cfin  = swap_ff ? ssum_ff : csum_ff;
      rnd_s = sfin + HALF_Q;
      rnd_c = cfin + HALF_Q;
      rs    = $signed(CW'(rnd_s[QW-1 -: COEF_FRAC+1]));
      rc    = $signed(CW'(rnd_c[QW-1 -: COEF_FRAC+1]));
      case (k_ff[1:0])
         2'd0: begin
            s_q = rs;
            c_q = rc;
         end
         2'd1: begin
            s_q = rc;
            c_q = -rs;
         end
         2'd2: begin
            s_q = -rs;
            c_q = -rc;
         end
         default: begin
            s_q = -rc;
            c_q = rs;
         end
      endcase
      s_f = neg_ff ? -s_q : s_q;
   end

   function automatic logic signed [CW-1:0] op_value(input opsel_type sel,
         input logic signed [CW-1:0] sps, input logic signed [CW-1:0] cps,
         input logic signed [CW-1:0] sth, input logic signed [CW-1:0] cth,
         input logic signed [CW-1:0] sph, input logic signed [CW-1:0] cph,
         input logic signed [CW-1:0] u, input logic signed [CW-1:0] w);
      logic signed [CW-1:0] v;
      case (sel)
         OPS_SPS: v = sps;
         OPS_CPS: v = cps;
         OPS_STH: v = sth;
         OPS_CTH: v = cth;
         OPS_SPH: v = sph;
         OPS_CPH: v = cph;
         OPS_U:   v = u;
         OPS_W:   v = w;
         default: v = ONE_C;
      endcase
      return v;
   endfunction

   // Matrix assembly
   always_comb begin
      cur_step = step_decode(step_ff);
      op_a_val = op_value(cur_step.op_a, sps_ff, cps_ff, sth_ff, cth_ff, sph_ff, cph_ff,
                          u_ff, w_ff);
      op_b_val = op_value(cur_step.op_b, sps_ff, cps_ff, sth_ff, cth_ff, sph_ff, cph_ff,
                          u_ff, w_ff);
      rnd_p    = prod_ff + HALF_P;
      pval     = CW'(rnd_p >>> COEF_FRAC);
      if (cur_step.dest == DEST_U) begin
         cur_val = u_ff;
      end else if (cur_step.dest == DEST_W) begin
         cur_val = w_ff;
      end else begin
         cur_val = mat_ff[cur_step.dest];
      end
      case (cur_step.mode)
         MODE_SET: new_val = pval;
         MODE_NEG: new_val = -pval;
         MODE_ADD: new_val = cur_val + pval;
         default:  new_val = cur_val - pval;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 2'd0;
         psi_ff   <= '0;
         theta_ff <= '0;
         phi_ff   <= '0;
         for (int i = 0; i < 9; i++) begin
            mat_ff[i] <= ((i % 4) == 0) ? ONE_C : '0;
         end
      end else if (angle_wr) begin
         // Any angle write restarts the rebuild from the first angle.
         case (csr_index)
            CSR_ANGLE_PSI:   psi_ff   <= csr_angle;
            CSR_ANGLE_THETA: theta_ff <= csr_angle;
            default:         phi_ff   <= csr_angle;
         endcase
         state_ff <= ST_LOAD;
         idx_ff   <= 2'd0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               neg_ff   <= angle_sel[ANGLE_WIDTH-1];
               x_ff     <= {mag, 48'd0};
               k_ff     <= 3'd0;
               state_ff <= ST_REDUCE;
            end
            ST_REDUCE: begin
               if (x_ff >= HALF_PI_Q60) begin
                  x_ff <= x_ff - HALF_PI_Q60;
                  k_ff <= k_ff + 3'd1;
               end else begin
                  state_ff <= ST_FOLD;
               end
            end
            ST_FOLD: begin
               swap_ff      <= (x_ff > QUARTER_PI_Q60);
               if (x_ff > QUARTER_PI_Q60) begin
                  x_ff    <= HALF_PI_Q60 - x_ff;
                  ssum_ff <= QW'(HALF_PI_Q60 - x_ff);
                  term_ff <= QW'(HALF_PI_Q60 - x_ff);
               end else begin
                  ssum_ff <= x_ff[QW-1:0];
                  term_ff <= x_ff[QW-1:0];
               end
               n_ff         <= 6'd1;
               cos_phase_ff <= 1'b0;
               state_ff     <= ST_CHECK;
            end
            ST_CHECK: begin
               if (n_ff < TERM_LIMIT && term_ff != '0) begin
                  mpass_ff <= 1'b0;
                  mstep_ff <= 2'd0;
                  state_ff <= ST_MUL;
               end else if (!cos_phase_ff) begin
                  csum_ff      <= ONE_Q;
                  term_ff      <= ONE_Q;
                  n_ff         <= 6'd0;
                  cos_phase_ff <= 1'b1;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_MUL: begin
               acc_ff   <= acc_sum;
               mstep_ff <= mstep_ff + 2'd1;
               if (mstep_ff == 2'd3) begin
                  t_ff <= acc_sum[Q60_FRAC+QW-1:Q60_FRAC];
                  if (mpass_ff) begin
                     rem_ff   <= '0;
                     q_ff     <= '0;
                     dcnt_ff  <= 6'd0;
                     state_ff <= ST_DIV;
                  end else begin
                     mpass_ff <= 1'b1;
                  end
               end
            end
            ST_DIV: begin
               rem_ff  <= qbit ? DIV_WIDTH'(r2 - {1'b0, dvsr}) : r2[DIV_WIDTH-1:0];
               q_ff    <= {q_ff[QW-2:0], qbit};
               t_ff    <= {t_ff[QW-2:0], 1'b0};
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'(QW - 1)) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               if (cos_phase_ff) begin
                  csum_ff <= sum_upd;
               end else begin
                  ssum_ff <= sum_upd;
               end
               term_ff  <= q_ff;
               n_ff     <= n_ff + 6'd2;
               state_ff <= ST_CHECK;
            end
            ST_FIN: begin
               case (idx_ff)
                  2'd0: begin
                     sps_ff <= s_f;
                     cps_ff <= c_q;
                  end
                  2'd1: begin
                     sth_ff <= s_f;
                     cth_ff <= c_q;
                  end
                  default: begin
                     sph_ff <= s_f;
                     cph_ff <= c_q;
                  end
               endcase
               if (idx_ff == 2'd2) begin
                  step_ff  <= 4'd0;
                  state_ff <= ST_MAT_MUL;
               end else begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_MAT_MUL: begin
               prod_ff  <= op_a_val * op_b_val;
               state_ff <= ST_MAT_ACC;
            end
            ST_MAT_ACC: begin
               if (cur_step.dest == DEST_U) begin
                  u_ff <= new_val;
               end else if (cur_step.dest == DEST_W) begin
                  w_ff <= new_val;
               end else begin
                  mat_ff[cur_step.dest] <= new_val;
               end
               step_ff <= step_ff + 4'd1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_MAT_MUL;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/euler_rigid_body_transform_unit.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake      Contents of one item
// req_ch   in         valid / ready  coord_x, coord_y, coord_z, last_atom
// rsp_ch   out        valid / ready  out_x, out_y, out_z, last_out, clipped
// csr_*    in         csr_wr_en      csr_index selects register, csr_wr_data
//
// One item is accepted every cycle unless the stages are full or a rebuild runs; each
// result passes the input, product and result registers in turn before it is offered.
// Stages squeeze out bubbles, so an empty stage takes an item while a result waits.
// Reset is synchronous; the matrix comes out of reset as the identity at once.
// An angle write rebuilds the matrix through one shared series unit, and input is
// held off until the rebuild is done.

module euler_rigid_body_transform_unit #(
   parameter int COORD_WIDTH = erbt_pkg::COORD_WIDTH_DEF,
   parameter int COEF_FRAC   = erbt_pkg::COEF_FRAC_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   erbt_req_if.sink                             req_ch,
   erbt_rsp_if.source                           rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [erbt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_wr_data
);
   import erbt_pkg::*;

   // Coefficients carry three integer bits above COEF_FRAC fraction bits.
   localparam int CW = COEF_FRAC + 3;
   // A coordinate times a coefficient, the sum of three of them, and the
   // rounded sum with the offset added.
   localparam int PW = COORD_WIDTH + CW;
   localparam int SW = PW + 2;
   localparam int RW = SW - COEF_FRAC + 1;
   localparam logic signed [SW-1:0] HALF_S = SW'(1) <<< (COEF_FRAC - 1);

   logic                          busy;
   logic signed [CW-1:0]          coef [9];

   logic signed [COORD_WIDTH-1:0] off_ff [3];

   // Input register
   logic                          v1_ff;
   logic signed [COORD_WIDTH-1:0] c1_ff [3];
   logic                          last1_ff;
   // Product register
   logic                          v2_ff;
   logic signed [PW-1:0]          prod_ff [9];
   logic                          last2_ff;
   // Result register
   logic                          v3_ff;
   logic signed [COORD_WIDTH-1:0] out_ff [3];
   logic                          last3_ff;
   logic                          clip3_ff;

   logic                          ready1, ready2, ready3, accept;
   logic signed [COORD_WIDTH-1:0] res_row [3];
   logic [2:0]                    clip_row;

   erbt_coef #(
      .COEF_FRAC(COEF_FRAC)
   ) u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_angle (csr_wr_data[ANGLE_WIDTH-1:0]),
      .busy      (busy),
      .coef      (coef)
   );

   // Translation registers; writes to unknown indexes fall through harmlessly.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            off_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OFFSET_X: off_ff[0] <= csr_wr_data;
            CSR_OFFSET_Y: off_ff[1] <= csr_wr_data;
            CSR_OFFSET_Z: off_ff[2] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Each stage loads when it is empty or its contents move on this cycle.
   assign ready3       = !v3_ff || rsp_ch.ready;
   assign ready2       = !v2_ff || ready3;
   assign ready1       = !v1_ff || ready2;
   assign req_ch.ready = ready1 && !busy;
   assign accept       = req_ch.valid && req_ch.ready;

   // Rounding, translation and saturation of each row.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         logic signed [SW-1:0] sum;
         logic signed [RW-1:0] val;
         logic                 sat_hi, sat_lo;
         sum = SW'(prod_ff[3*r]) + SW'(prod_ff[3*r+1]) + SW'(prod_ff[3*r+2]) + HALF_S;
         val = RW'(sum >>> COEF_FRAC) + RW'(off_ff[r]);
         sat_hi = !val[RW-1] && (|val[RW-2:COORD_WIDTH-1]);
         sat_lo = val[RW-1] && !(&val[RW-2:COORD_WIDTH-1]);
         if (sat_hi) begin
            res_row[r] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end else if (sat_lo) begin
            res_row[r] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         end else begin
            res_row[r] = val[COORD_WIDTH-1:0];
         end
         clip_row[r] = sat_hi || sat_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= accept;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         c1_ff[0] <= req_ch.coord_x;
         c1_ff[1] <= req_ch.coord_y;
         c1_ff[2] <= req_ch.coord_z;
         last1_ff <= req_ch.last_atom;
      end
      if (ready2) begin
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= PW'(c1_ff[i % 3]) * PW'(coef[i]);
         end
         last2_ff <= last1_ff;
      end
      if (ready3) begin
         for (int r = 0; r < 3; r++) begin
            out_ff[r] <= res_row[r];
         end
         last3_ff <= last2_ff;
         clip3_ff <= |clip_row;
      end
   end

   assign rsp_ch.valid    = v3_ff;
   assign rsp_ch.out_x    = out_ff[0];
   assign rsp_ch.out_y    = out_ff[1];
   assign rsp_ch.out_z    = out_ff[2];
   assign rsp_ch.last_out = last3_ff;
   assign rsp_ch.clipped  = clip3_ff;

endmodule

/* rtl/erbt_checker.sv */
`timescale 1ns / 1ps

module erbt_checker #(
   parameter int COORD_WIDTH = erbt_pkg::COORD_WIDTH_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [3*COORD_WIDTH+1:0]   rsp_payload
);
   logic [2:0] count_ff;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_ff + 3'(req_acc) - 3'(rsp_acc);
      end
   end

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != 3'd0)
      else $error("result shown with no item outstanding");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd3)
      else $error("more items outstanding than the pipeline holds");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind euler_rigid_body_transform_unit erbt_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_erbt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload ({rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.last_out,
                  rsp_ch.clipped})
);

/* tb/euler_rigid_body_transform_unit_tb.sv */
`timescale 1ns / 1ps

module euler_rigid_body_transform_unit_tb;

   import erbt_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int CF = COEF_FRAC_DEF;
   localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint COORD_MIN = -(64'sd1 <<< (CW - 1));
   localparam logic [CW-1:0] CMAX = COORD_MAX[CW-1:0];
   localparam logic [CW-1:0] CMIN = COORD_MIN[CW-1:0];
   localparam logic [CW-1:0] ANGLE_EXT = CW'(25736);

   // Indexes that the register map leaves unused; writes to them must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   localparam int RANDOM_PHASES = 8;
   localparam int POINTS_PER_PHASE = 205;
   localparam int HOLD_OFF_AT = 400;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 last;
   } point_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 last;
      logic                 clip;
   } pose_type;

   // The directed rows are grouped by the register setting that they are run under.
   typedef enum logic [1:0] {SETUP_RESET, SETUP_OFFSET_EXT, SETUP_ANGLE_EXT} setup_type;

   typedef struct packed {
      setup_type setup;
      point_type pt;
      logic      typed;
      pose_type  want;
   } row_type;

   logic clock;
   logic reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CW-1:0]              csr_wr_data;

   erbt_req_if #(.COORD_WIDTH(CW)) req_if ();
   erbt_rsp_if #(.COORD_WIDTH(CW)) rsp_if ();

   euler_rigid_body_transform_unit #(
      .COORD_WIDTH(CW),
      .COEF_FRAC  (CF)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // Local copy of the registers and of the matrix derived from the angles.
   logic [15:0]   angle_reg [3];
   logic [CW-1:0] offset_reg [3];
   longint        rot [9];

   pose_type pose_q [$];
   int    errors;
   int    poses_seen;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Product of two Q60 fractions, truncated back to Q60.
   function automatic longint unsigned mul_q60(input longint unsigned a, input longint unsigned b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // Round to nearest at CF fraction bits, ties upwards.
   function automatic longint round_frac(input longint v);
      return (v + (64'sd1 <<< (CF - 1))) >>> CF;
   endfunction

   function automatic longint coef_mul(input longint a, input longint b);
      return round_frac(a * b);
   endfunction

   // Sine and cosine of an angle in radians * 4096, by octant folding and Taylor series.
   task automatic sin_cos_q(input logic [15:0] raw, output longint s, output longint c);
      longint a;
      longint unsigned mag, x, term, ssum, csum, t;
      int k, n;
      bit swap;
      longint rs, rc;
      a = longint'($signed(raw));
      mag = (a < 0) ? -a : a;
      x = mag << 48;
      k = 0;
      while (x >= HALF_PI_Q60) begin
         x -= HALF_PI_Q60;
         k++;
      end
      swap = x > QUARTER_PI_Q60;
      if (swap) begin
         x = HALF_PI_Q60 - x;
      end
      ssum = x;
      term = x;
      for (n = 1; n < 40 && term != 0; n += 2) begin
         term = mul_q60(mul_q60(term, x), x) / longint'((n + 1) * (n + 2));
         ssum = (((n >> 1) & 1) == 0) ? ssum - term : ssum + term;
      end
      csum = 64'd1 << 60;
      term = 64'd1 << 60;
      for (n = 0; n < 40 && term != 0; n += 2) begin
         term = mul_q60(mul_q60(term, x), x) / longint'((n + 1) * (n + 2));
         csum = (((n >> 1) & 1) == 0) ? csum - term : csum + term;
      end
      if (swap) begin
         t = ssum;
         ssum = csum;
         csum = t;
      end
      rs = longint'((ssum + (64'd1 << (59 - CF))) >> (60 - CF));
      rc = longint'((csum + (64'd1 << (59 - CF))) >> (60 - CF));
      case (k & 3)
         0: begin s = rs;  c = rc;  end
         1: begin s = rc;  c = -rs; end
         2: begin s = -rs; c = -rc; end
         default: begin s = -rc; c = rs; end
      endcase
      if (a < 0) begin
         s = -s;
      end
   endtask

   task automatic rebuild_rotation();
      longint sps, cps, sth, cth, sph, cph, u, w;
      sin_cos_q(angle_reg[0], sps, cps);
      sin_cos_q(angle_reg[1], sth, cth);
      sin_cos_q(angle_reg[2], sph, cph);
      u = coef_mul(cth, sph);
      w = coef_mul(cth, cph);
      rot[0] = coef_mul(cps, cph) - coef_mul(sps, u);
      rot[1] = -coef_mul(cps, sph) - coef_mul(sps, w);
      rot[2] = coef_mul(sps, sth);
      rot[3] = coef_mul(sps, cph) + coef_mul(cps, u);
      rot[4] = -coef_mul(sps, sph) + coef_mul(cps, w);
      rot[5] = -coef_mul(cps, sth);
      rot[6] = coef_mul(sth, sph);
      rot[7] = coef_mul(sth, cph);
      rot[8] = cth;
   endtask

   function automatic pose_type transform_point(input point_type pt);
      pose_type r;
      longint   p [3];
      longint   acc, v;
      p[0] = longint'(pt.x);
      p[1] = longint'(pt.y);
      p[2] = longint'(pt.z);
      r.clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = p[0] * rot[3*i] + p[1] * rot[3*i+1] + p[2] * rot[3*i+2];
         v = round_frac(acc) + longint'($signed(offset_reg[i]));
         if (v > COORD_MAX) begin
            v = COORD_MAX;
            r.clip = 1'b1;
         end else if (v < COORD_MIN) begin
            v = COORD_MIN;
            r.clip = 1'b1;
         end
         case (i)
            0: r.x = v[CW-1:0];
            1: r.y = v[CW-1:0];
            default: r.z = v[CW-1:0];
         endcase
      end
      r.last = pt.last;
      return r;
   endfunction

   // Mostly no gap, sometimes a short one and now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CW-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            default: return '1;
         endcase
      end
      if (r < 4) return CW'($signed($urandom_range(0, 8191)) - 4096);
      return CW'($urandom);
   endfunction

   // One register write; the enable stays high so that writes may follow back to back.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [CW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      if (idx <= CSR_ANGLE_PHI) begin
         angle_reg[idx] = data[15:0];
         rebuild_rotation();
      end else if (idx <= CSR_OFFSET_Z) begin
         offset_reg[idx - CSR_OFFSET_X] = data;
      end
   endtask

   task automatic end_writes();
      csr_wr_en <= 1'b0;
   endtask

   // Registers may only change once every pose has come back and the pipe is empty.
   task automatic drain();
      while (pose_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic send_point(input point_type pt, input logic typed, input pose_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.coord_x   <= pt.x;
      req_if.coord_y   <= pt.y;
      req_if.coord_z   <= pt.z;
      req_if.last_atom <= pt.last;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      pose_q.push_back(typed ? want : transform_point(pt));
   endtask

   // Directed rows. Under the reset setting the matrix is the identity with no offset,
   // so each pose is the point itself. Full-scale offsets clip the sums that overflow.
   row_type directed [] = '{
      '{SETUP_RESET, '{'0, '0, '0, 1'b0}, 1'b1, '{'0, '0, '0, 1'b0, 1'b0}},
      '{SETUP_RESET, '{CMAX, CMAX, CMAX, 1'b1}, 1'b1, '{CMAX, CMAX, CMAX, 1'b1, 1'b0}},
      '{SETUP_RESET, '{CMIN, CMIN, CMIN, 1'b0}, 1'b1, '{CMIN, CMIN, CMIN, 1'b0, 1'b0}},
      '{SETUP_RESET, '{CMAX, CMIN, '1, 1'b1}, 1'b1, '{CMAX, CMIN, '1, 1'b1, 1'b0}},
      '{SETUP_RESET, '{CW'(1), CW'(2), CW'(3), 1'b0}, 1'b1,
        '{CW'(1), CW'(2), CW'(3), 1'b0, 1'b0}},
      '{SETUP_RESET, '{'1, CW'(1), CMAX, 1'b0}, 1'b0, '0},
      '{SETUP_OFFSET_EXT, '{CMAX, CMIN, '0, 1'b1}, 1'b1, '{CMAX, CMIN, '0, 1'b1, 1'b1}},
      '{SETUP_OFFSET_EXT, '{CMIN, CMAX, CMAX, 1'b0}, 1'b1, '{'1, '1, CMAX, 1'b0, 1'b0}},
      '{SETUP_OFFSET_EXT, '{'0, '0, CMIN, 1'b1}, 1'b1, '{CMAX, CMIN, CMIN, 1'b1, 1'b0}},
      '{SETUP_OFFSET_EXT, '{CW'(1), '1, '0, 1'b0}, 1'b1, '{CMAX, CMIN, '0, 1'b0, 1'b1}},
      '{SETUP_ANGLE_EXT, '{CMAX, CMAX, CMAX, 1'b0}, 1'b0, '0},
      '{SETUP_ANGLE_EXT, '{CMIN, CMIN, CMIN, 1'b1}, 1'b0, '0},
      '{SETUP_ANGLE_EXT, '{CMAX, CMIN, '0, 1'b0}, 1'b0, '0},
      '{SETUP_ANGLE_EXT, '{CW'(4096), '0, '0, 1'b1}, 1'b0, '0},
      '{SETUP_ANGLE_EXT, '{'0, CW'(4096), '0, 1'b0}, 1'b0, '0},
      '{SETUP_ANGLE_EXT, '{'0, '0, CW'(4096), 1'b1}, 1'b0, '0}
   };

   // Puts the block in the register setting that a group of directed rows needs.
   task automatic apply_setup(input setup_type setup);
      case (setup)
         SETUP_OFFSET_EXT: begin
            write_reg(CSR_OFFSET_X, CMAX);
            write_reg(CSR_OFFSET_Y, CMIN);
            write_reg(CSR_OFFSET_Z, '0);
         end
         SETUP_ANGLE_EXT: begin
            write_reg(CSR_ANGLE_PSI, ANGLE_EXT);
            write_reg(CSR_ANGLE_THETA, -ANGLE_EXT);
            write_reg(CSR_ANGLE_PHI, ANGLE_EXT);
            write_reg(CSR_OFFSET_X, '0);
            write_reg(CSR_OFFSET_Y, CW'(1024));
            write_reg(CSR_OFFSET_Z, '1);
         end
         default: begin
         end
      endcase
      end_writes();
   endtask

   // A random setting per phase. The first two pin the angles at 25736 and -25736, about 2*pi;
   // the rest use any 16-bit angle, with junk in the unused upper bits of the data.
   task automatic random_setup(input int phase);
      logic [CW-1:0] a;
      for (int i = 0; i < 3; i++) begin
         if (phase == 0) a = ANGLE_EXT;
         else if (phase == 1) a = -ANGLE_EXT;
         else a = CW'($urandom);
         write_reg(CSR_ANGLE_PSI + CSR_INDEX_WIDTH'(i), a);
      end
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 5))
            0: a = CMAX;
            1: a = CMIN;
            2: a = '0;
            3: a = CW'($signed($urandom_range(0, 65535)) - 32768);
            default: a = CW'($urandom);
         endcase
         write_reg(CSR_OFFSET_X + CSR_INDEX_WIDTH'(i), a);
      end
      write_reg(CSR_SPARE_LO, CW'($urandom));
      write_reg(CSR_SPARE_HI, CW'($urandom));
      end_writes();
   endtask

   initial begin
      point_type pt;
      setup_type current;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= '0;
      csr_wr_data      <= '0;
      req_if.valid     <= 1'b0;
      req_if.coord_x   <= '0;
      req_if.coord_y   <= '0;
      req_if.coord_z   <= '0;
      req_if.last_atom <= 1'b0;
      errors = 0;
      for (int i = 0; i < 3; i++) begin
         angle_reg[i]  = '0;
         offset_reg[i] = '0;
      end
      rebuild_rotation();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      current = SETUP_RESET;
      foreach (directed[i]) begin
         if (directed[i].setup != current) begin
            req_if.valid <= 1'b0;
            drain();
            current = directed[i].setup;
            apply_setup(current);
         end
         send_point(directed[i].pt, directed[i].typed, directed[i].want);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         req_if.valid <= 1'b0;
         drain();
         random_setup(ph);
         for (int n = 0; n < POINTS_PER_PHASE; n++) begin
            pt.x = pick_coord();
            pt.y = pick_coord();
            pt.z = pick_coord();
            pt.last = ($urandom_range(0, 7) == 0);
            send_point(pt, 1'b0, '0);
         end
      end
      req_if.valid <= 1'b0;
      drain();
      repeat (10) @(posedge clock);

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // The receiver: random stalls, and one long hold-off once the stream is under way,
   // so that the stages fill and the request side must stall.
   initial begin
      int  gap;
      bit  held;
      rsp_if.ready <= 1'b0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && poses_seen >= HOLD_OFF_AT) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // Every accepted pose is compared with the oldest one predicted.
   initial poses_seen = 0;

   always @(posedge clock) begin
      pose_type want;
      pose_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         poses_seen <= poses_seen + 1;
         got = '{rsp_if.out_x, rsp_if.out_y, rsp_if.out_z, rsp_if.last_out, rsp_if.clipped};
         if (pose_q.size() == 0) begin
            $display("%0t: unexpected pose, got %h", $realtime, got);
            errors++;
         end else begin
            want = pose_q.pop_front();
            if (got.x !== want.x) begin
               $display("%0t: out_x expected %h actual %h", $realtime, want.x, got.x);
               errors++;
            end
            if (got.y !== want.y) begin
               $display("%0t: out_y expected %h actual %h", $realtime, want.y, got.y);
               errors++;
            end
            if (got.z !== want.z) begin
               $display("%0t: out_z expected %h actual %h", $realtime, want.z, got.z);
               errors++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last_out expected %b actual %b", $realtime, want.last, got.last);
               errors++;
            end
            if (got.clip !== want.clip) begin
               $display("%0t: clipped expected %b actual %b", $realtime, want.clip, got.clip);
               errors++;
            end
         end
      end
   end

   // Watchdog: allows for every angle rebuild, the stalls and the hold-off many times over.
   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
rtl/erbt_pkg.sv
rtl/erbt_req_if.sv
rtl/erbt_rsp_if.sv
rtl/erbt_coef.sv
rtl/euler_rigid_body_transform_unit.sv
rtl/erbt_checker.sv
tb/euler_rigid_body_transform_unit_tb.sv
